[rtl/ocf_pkg.sv]
// ----------------------------------------------------------------------------
// ocf_pkg - shared types and constants for the opcode framer
// Word layouts of both channels, op codes and framing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ocf_pkg;

  typedef enum logic [1:0] {
    OP_RECV = 2'd0,
    OP_SENT = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       sent_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       in_message;
    logic       message_first;
    logic       message_last;
    logic       is_echo;
    logic       dropped;
    logic       echo_timed_out;
    logic       bus_busy;
    logic       send_ready;
  } out_word_t;

  localparam int unsigned MAX_MSG_DEF   = 128;
  localparam logic [15:0] ECHO_WAIT_RST = 16'd100;
  localparam logic [7:0]  BUSY_OPC      = 8'h81;
  localparam logic [8:0]  MIN_EXT_LEN   = 9'd3;

  // opcode high nibbles
  localparam logic [3:0] NIB_LEN2  = 4'h8;
  localparam logic [3:0] NIB_LEN4A = 4'hA;
  localparam logic [3:0] NIB_LEN4B = 4'hB;
  localparam logic [3:0] NIB_LEN6  = 4'hC;
  localparam logic [3:0] NIB_EXT   = 4'hE;

endpackage

`default_nettype wire

[rtl/opcode_framer_with_echo_check.sv]
// ----------------------------------------------------------------------------
// opcode_framer_with_echo_check - bus message framer with echo check
// Top level: framer, sent byte store and result buffer.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while in_ready is high. Its result word
// goes into the output register, or the skid slot during a stall; each input
// word gives exactly one result word. The rate is set by the state update in
// the framer, which compares against a store byte fetched ahead for the next
// byte position. A two-entry result buffer keeps intake running while a
// result is stalled; in_ready drops only when both are full. The sent byte
// store has no reset and needs no clearing pass. cfg_we writes wait_r.
`default_nettype none

module opcode_framer_with_echo_check #(
  parameter int unsigned MAX_MSG = ocf_pkg::MAX_MSG_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ocf_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ocf_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int unsigned PW = $clog2(MAX_MSG);

  logic               acc;
  logic               st_we;
  logic [PW-1:0]      st_waddr;
  logic [PW-1:0]      st_raddr;
  logic [7:0]         rd_data;
  ocf_pkg::out_word_t res;

  assign acc = in_valid && in_ready;

  ocf_framer #(.MAX_MSG(MAX_MSG)) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_data   (rd_data),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_raddr  (st_raddr),
    .res       (res)
  );

  ocf_store #(.MAX_MSG(MAX_MSG)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_data.data_byte),
    .raddr (st_raddr),
    .rdata (rd_data)
  );

  ocf_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_ready  (in_ready),
    .in_word   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_data)
  );

endmodule

`default_nettype wire

[rtl/ocf_store.sv]
// ----------------------------------------------------------------------------
// ocf_store - sent message byte store
// Single write port, registered read with write-through on address match.
// ----------------------------------------------------------------------------
`default_nettype none

module ocf_store #(
  parameter  int unsigned MAX_MSG = ocf_pkg::MAX_MSG_DEF,
  localparam int unsigned PW      = $clog2(MAX_MSG)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [PW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [PW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem_r [MAX_MSG];
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rd_r <= wdata;
    end else begin
      rd_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

`default_nettype wire

[rtl/ocf_framer.sv]
// ----------------------------------------------------------------------------
// ocf_framer - message framing and echo tracking
// Per-word state update; drives the store and produces one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ocf_framer #(
  parameter  int unsigned MAX_MSG = ocf_pkg::MAX_MSG_DEF,
  localparam int unsigned PW      = $clog2(MAX_MSG),
  localparam int unsigned LW      = $clog2(MAX_MSG + 1),
  localparam int unsigned FW      = $clog2(MAX_MSG + 2)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire ocf_pkg::in_word_t  in_data,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic [7:0]         rd_data,
  output logic                    st_we,
  output logic      [PW-1:0]      st_waddr,
  output logic      [PW-1:0]      st_raddr,
  output ocf_pkg::out_word_t      res
);

  localparam logic [8:0]    MAX9   = 9'(MAX_MSG);
  localparam logic [FW-1:0] MAX_FW = FW'(MAX_MSG);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] exp_r, exp_nxt;
  logic          match_r, match_nxt;
  logic          busy_r, busy_nxt;
  logic          opc_r, opc_nxt;
  logic          pend_r, pend_nxt;
  logic [15:0]   ticks_r, ticks_nxt;
  logic [FW-1:0] slen_r, slen_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   wait_r, wait_nxt;

  logic [7:0]    b;
  logic [8:0]    b9;
  logic          hit;
  logic          match_v;
  logic [LW-1:0] len_v;
  logic          len_ok;
  logic [LW-1:0] pos_inc;
  logic [FW-1:0] fill_inc;
  logic [15:0]   tick_inc;

  assign b        = in_data.data_byte;
  assign b9       = {1'b0, b};
  assign hit      = (FW'(pos_r) < slen_r) && (rd_data == b);
  assign match_v  = match_r && hit;
  assign pos_inc  = LW'(pos_r) + LW'(1);
  assign fill_inc = fill_r + FW'(1);
  assign tick_inc = ticks_r + 16'd1;

  always_comb begin
    len_ok = 1'b1;
    len_v  = '0;
    unique case (b[7:4])
      ocf_pkg::NIB_LEN2:  len_v = LW'(2);
      ocf_pkg::NIB_LEN4A: len_v = LW'(4);
      ocf_pkg::NIB_LEN4B: len_v = LW'(4);
      ocf_pkg::NIB_LEN6:  len_v = LW'(6);
      ocf_pkg::NIB_EXT:   len_v = '0;
      default:            len_ok = 1'b0;
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    match_nxt = match_r;
    busy_nxt  = busy_r;
    opc_nxt   = opc_r;
    pend_nxt  = pend_r;
    ticks_nxt = ticks_r;
    slen_nxt  = slen_r;
    fill_nxt  = fill_r;
    wait_nxt  = cfg_we ? cfg_wdata : wait_r;
    st_we     = 1'b0;
    res       = '0;

    if (acc) begin
      unique case (in_data.op)
        ocf_pkg::OP_RECV: begin
          res.byte_out = b;
          if (pos_r == '0) begin
            if (!b[7] || !len_ok) begin
              res.dropped = 1'b1;
            end else begin
              res.in_message    = 1'b1;
              res.message_first = 1'b1;
              exp_nxt           = len_v;
              pos_nxt           = PW'(1);
              opc_nxt           = (b == ocf_pkg::BUSY_OPC);
              match_nxt         = hit;
            end
          end else if ((pos_r == PW'(1)) && (exp_r == '0)) begin
            if ((b9 < ocf_pkg::MIN_EXT_LEN) || (b9 > MAX9)) begin
              res.dropped = 1'b1;
              pos_nxt     = '0;
              match_nxt   = 1'b0;
            end else begin
              res.in_message = 1'b1;
              exp_nxt        = LW'(b);
              match_nxt      = match_v;
              pos_nxt        = PW'(2);
            end
          end else begin
            res.in_message = 1'b1;
            if (pos_inc >= exp_r) begin
              res.message_last = 1'b1;
              busy_nxt         = opc_r;
              if (pend_r && match_v && (FW'(exp_r) == slen_r)) begin
                res.is_echo = 1'b1;
                pend_nxt    = 1'b0;
                ticks_nxt   = '0;
              end
              pos_nxt   = '0;
              exp_nxt   = '0;
              match_nxt = 1'b0;
            end else begin
              pos_nxt   = PW'(pos_inc);
              match_nxt = match_v;
            end
          end
        end
        ocf_pkg::OP_SENT: begin
          match_nxt = 1'b0;
          st_we     = (fill_r < MAX_FW);
          if (in_data.sent_last) begin
            slen_nxt  = (fill_r <= MAX_FW) ? fill_inc : fill_r;
            fill_nxt  = '0;
            pend_nxt  = 1'b1;
            ticks_nxt = '0;
          end else if (fill_r <= MAX_FW) begin
            fill_nxt = fill_inc;
          end
        end
        ocf_pkg::OP_TICK: begin
          if (pend_r) begin
            if (tick_inc >= wait_r) begin
              res.echo_timed_out = 1'b1;
              pend_nxt           = 1'b0;
              ticks_nxt          = '0;
            end else begin
              ticks_nxt = tick_inc;
            end
          end
        end
        ocf_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
      res.bus_busy   = busy_nxt;
      res.send_ready = !busy_nxt && !pend_nxt;
    end
  end

  assign st_waddr = PW'(fill_r);
  assign st_raddr = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      exp_r   <= '0;
      match_r <= 1'b0;
      busy_r  <= 1'b0;
      opc_r   <= 1'b0;
      pend_r  <= 1'b0;
      ticks_r <= '0;
      slen_r  <= '0;
      fill_r  <= '0;
      wait_r  <= ocf_pkg::ECHO_WAIT_RST;
    end else begin
      pos_r   <= pos_nxt;
      exp_r   <= exp_nxt;
      match_r <= match_nxt;
      busy_r  <= busy_nxt;
      opc_r   <= opc_nxt;
      pend_r  <= pend_nxt;
      ticks_r <= ticks_nxt;
      slen_r  <= slen_nxt;
      fill_r  <= fill_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ocf_skid.sv]
// ----------------------------------------------------------------------------
// ocf_skid - two-entry result buffer
// Output register plus skid slot; intake stops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ocf_skid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ocf_pkg::out_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ocf_pkg::out_word_t      out_word
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  ocf_pkg::out_word_t main_d_r, main_d_nxt;
  ocf_pkg::out_word_t skid_d_r, skid_d_nxt;
  logic               adv;

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_word  = main_d_r;
  assign adv       = out_ready || !main_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (adv) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = in_valid;
        main_d_nxt = in_word;
      end
    end else if (in_valid && in_ready) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid slot full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (main_v_r && !skid_v_r && (main_d_r == $past(skid_d_r))))
    else $error("skid word not moved to output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !out_ready && in_valid && !skid_v_r) |=> (skid_v_r && $stable(main_d_r)))
    else $error("word lost during output stall");

endmodule

`default_nettype wire
